@@ hdl/md5sh_pkg.sv @@
// Package with MD5 constants, types and helper functions for the stream hasher.
`timescale 1ns / 1ps
package md5sh_pkg;

    localparam int FuncWidth = 2;
    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_APPEND_FINISH = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;
    localparam logic [1:0] FUNC_IGNORED = 2'd3;

    localparam int QueueDepth = 4;
    localparam int CountWidth = 61;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Queue entry: one classified operation for the back end.
    typedef struct packed {
        logic       has_byte;
        logic       finish;
        logic [7:0] data_byte;
    } md5sh_op_t;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word index used by round i.
    function automatic logic [3:0] word_index(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            2'd3: g = 4'(7 * i[3:0]);
            default: g = 4'd0;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] byte_swap(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

@@ hdl/md5_stream_hasher.sv @@
// Top level of the streaming MD5 hasher: front queue and back compression engine.
//
// Channel  Dir  Transaction  Payload
// s_axis   in   one op       tuser = func, tdata = data_byte
// m_axis   out  one digest   tdata = {digest_low, digest_high}
//
// Appending the 64th byte of a block starts a compression: a fetch state, 64
// rounds and a chaining add. A finish pads the block and writes the length, runs
// one compression, or two with zero fill and length between them when the marker
// byte lands at position 56 or later, and then presents the digest. Reset returns
// the chaining words to the initial values. A digest waiting at the output holds
// the back end once the next digest is ready; the four-entry queue keeps accepting
// input transactions until it fills.
`timescale 1ns / 1ps
module md5_stream_hasher
    import md5sh_pkg::*;
#(
    parameter int Depth = QueueDepth
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]   s_axis_tuser,   // [1:0] func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // [63:0] digest_high, [127:64] digest_low
);

    logic        op_valid, op_ready;
    md5sh_op_t   op;
    logic [63:0] digest_high, digest_low;

    md5sh_front #(.Depth(Depth)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .func      (s_axis_tuser),
        .data_byte (s_axis_tdata),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op        (op)
    );

    md5sh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (op_valid),
        .op_ready    (op_ready),
        .op          (op),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .digest_high (digest_high),
        .digest_low  (digest_low)
    );

    assign m_axis_tdata = {digest_low, digest_high};

endmodule

@@ hdl/md5sh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module md5sh_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/md5sh_front.sv @@
// Front end: accepts stream transactions, classifies them and queues operations.
`timescale 1ns / 1ps
module md5sh_front
    import md5sh_pkg::*;
#(
    parameter int Depth = QueueDepth
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] data_byte,
    output logic       op_valid,
    input  logic       op_ready,
    output md5sh_op_t  op
);

    localparam int PtrWidth = $clog2(Depth);

    md5sh_op_t             queue_reg [Depth];
    logic [PtrWidth-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PtrWidth:0]     count_reg;
    logic                  push, pop;
    md5sh_op_t             entry;

    assign in_ready = (count_reg != (PtrWidth + 1)'(Depth));
    // An unused selector is accepted and dropped here.
    assign push = in_valid && in_ready && (func != FUNC_IGNORED);
    assign op_valid = (count_reg != '0);
    assign pop = op_valid && op_ready;
    assign op = queue_reg[rd_ptr_reg];

    always_comb
    begin
        entry.has_byte = (func == FUNC_APPEND) || (func == FUNC_APPEND_FINISH);
        entry.finish = (func == FUNC_APPEND_FINISH) || (func == FUNC_FINISH);
        entry.data_byte = data_byte;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PtrWidth + 1)'(push) - (PtrWidth + 1)'(pop);
        end
    end

endmodule

@@ hdl/md5sh_back.sv @@
// Back end: block assembly, padding and the iterative MD5 compression rounds.
`timescale 1ns / 1ps
module md5sh_back
    import md5sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        op_valid,
    output logic        op_ready,
    input  md5sh_op_t   op,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_high,
    output logic [63:0] digest_low
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PAD    = 7'b0000010,
        ST_LEN    = 7'b0000100,
        ST_ROUND  = 7'b0001000,
        ST_ADD    = 7'b0010000,
        ST_OUT    = 7'b0100000,
        ST_FETCH  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [CountWidth-1:0] count_reg;
    logic [1:0]            lane_reg;      // byte lane within the word being built
    logic [23:0]           partial_reg;   // low bytes of the current word
    logic [3:0]            pad_word_reg;
    logic                  finishing_reg, second_reg;
    logic                  data_block_reg; // compression of a block filled by data
    logic [5:0]            round_reg;
    logic [31:0]           a_reg, b_reg, c_reg, d_reg;
    logic [31:0]           h0_reg, h1_reg, h2_reg, h3_reg;
    logic [63:0]           dhigh_reg, dlow_reg;
    logic                  out_valid_reg;

    logic        ram_we;
    logic [3:0]  ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata;

    md5sh_ram #(.Width(32), .Depth(16)) u_words (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    logic [63:0] bit_len;
    logic [5:0]  pos;
    logic [31:0] f_val, sum, rot;
    logic [4:0]  sh;
    logic        take_byte;

    assign bit_len = {count_reg, 3'b000};
    assign pos = count_reg[5:0];
    assign op_ready = (state_reg == ST_IDLE);
    assign take_byte = op_valid && op_ready && op.has_byte;
    assign out_valid = out_valid_reg;
    assign digest_high = dhigh_reg;
    assign digest_low = dlow_reg;

    // Read address runs one round ahead so data arrives with its round.
    assign ram_raddr = (state_reg == ST_FETCH) ? word_index(6'd0)
                     : word_index(round_reg + 6'd1);

    always_comb
    begin
        case (round_reg[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            2'd3: f_val = c_reg ^ (b_reg | ~d_reg);
            default: f_val = '0;
        endcase
        sum = a_reg + f_val + round_const(round_reg) + ram_rdata;
        sh = rot_amount(round_reg);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = pos[5:2];
        ram_wdata = {op.data_byte, partial_reg};
        case (state_reg)
            ST_IDLE:
            begin
                if (take_byte && (lane_reg == 2'd3))
                begin
                    ram_we = 1'b1;
                end
            end
            ST_PAD:
            begin
                ram_we = 1'b1;
                ram_waddr = pad_word_reg;
                ram_wdata = '0;
                if (pad_word_reg == pos[5:2] && !second_reg)
                begin
                    // Word holding the marker byte keeps the bytes below it.
                    case (pos[1:0])
                        2'd0: ram_wdata = {24'h0, PAD_BYTE};
                        2'd1: ram_wdata = {16'h0, PAD_BYTE, partial_reg[7:0]};
                        2'd2: ram_wdata = {8'h0, PAD_BYTE, partial_reg[15:0]};
                        2'd3: ram_wdata = {PAD_BYTE, partial_reg};
                        default: ram_wdata = '0;
                    endcase
                end
            end
            ST_LEN:
            begin
                ram_we = 1'b1;
                ram_waddr = pad_word_reg;
                ram_wdata = pad_word_reg[0] ? bit_len[63:32] : bit_len[31:0];
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    if (op.has_byte && pos == 6'd63)
                    begin
                        state_next = ST_FETCH;
                    end
                    else if (op.finish)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_word_reg == 4'd15)
                begin
                    state_next = (!second_reg && pos >= 6'd56) ? ST_FETCH : ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (pad_word_reg == 4'd15)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (data_block_reg)
                begin
                    // The byte that filled the block may also finish the message.
                    state_next = finishing_reg ? ST_PAD : ST_IDLE;
                end
                else if (finishing_reg && (second_reg || pos < 6'd56))
                begin
                    state_next = ST_OUT;
                end
                else if (finishing_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FETCH)
        begin
            a_reg <= h0_reg;
            b_reg <= h1_reg;
            c_reg <= h2_reg;
            d_reg <= h3_reg;
        end
        else if (state_reg == ST_ROUND)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
        if (take_byte)
        begin
            case (lane_reg)
                2'd0: partial_reg[7:0] <= op.data_byte;
                2'd1: partial_reg[15:8] <= op.data_byte;
                2'd2: partial_reg[23:16] <= op.data_byte;
                default: partial_reg <= partial_reg;
            endcase
        end
        if (state_reg == ST_OUT && !out_valid_reg)
        begin
            dhigh_reg <= {byte_swap(h0_reg), byte_swap(h1_reg)};
            dlow_reg <= {byte_swap(h2_reg), byte_swap(h3_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            lane_reg <= '0;
            pad_word_reg <= '0;
            finishing_reg <= 1'b0;
            second_reg <= 1'b0;
            data_block_reg <= 1'b0;
            round_reg <= '0;
            h0_reg <= INIT_A;
            h1_reg <= INIT_B;
            h2_reg <= INIT_C;
            h3_reg <= INIT_D;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (take_byte)
                    begin
                        count_reg <= count_reg + 1'b1;
                        lane_reg <= lane_reg + 1'b1;
                    end
                    if (op_valid)
                    begin
                        finishing_reg <= op.finish;
                        data_block_reg <= op.has_byte && pos == 6'd63;
                        second_reg <= 1'b0;
                        pad_word_reg <= take_byte ? 4'((pos + 6'd1) >> 2) : pos[5:2];
                    end
                end
                ST_PAD:
                begin
                    if (pad_word_reg != 4'd15)
                    begin
                        pad_word_reg <= pad_word_reg + 1'b1;
                    end
                    else if (!second_reg && pos >= 6'd56)
                    begin
                        pad_word_reg <= 4'd0;
                    end
                    else
                    begin
                        pad_word_reg <= 4'd14;
                    end
                end
                ST_LEN:
                begin
                    pad_word_reg <= pad_word_reg + 1'b1;
                end
                ST_FETCH: round_reg <= 6'd0;
                ST_ROUND: round_reg <= round_reg + 1'b1;
                ST_ADD:
                begin
                    h0_reg <= h0_reg + a_reg;
                    h1_reg <= h1_reg + b_reg;
                    h2_reg <= h2_reg + c_reg;
                    h3_reg <= h3_reg + d_reg;
                    data_block_reg <= 1'b0;
                    if (data_block_reg)
                    begin
                        // A finish after a full block pads a fresh block from byte 0.
                        second_reg <= 1'b0;
                        pad_word_reg <= 4'd0;
                    end
                    else if (finishing_reg && !(second_reg || pos < 6'd56))
                    begin
                        second_reg <= 1'b1;
                        pad_word_reg <= 4'd0;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        h0_reg <= INIT_A;
                        h1_reg <= INIT_B;
                        h2_reg <= INIT_C;
                        h3_reg <= INIT_D;
                        count_reg <= '0;
                        lane_reg <= '0;
                        finishing_reg <= 1'b0;
                        second_reg <= 1'b0;
                    end
                end
                default: round_reg <= round_reg;
            endcase
        end
    end

endmodule

@@ hdl/md5sh_checker.sv @@
// Port-level checker for the MD5 stream hasher, bound to the top level.
`timescale 1ns / 1ps
module md5sh_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // A digest needs at least one compression, so two never come back to back.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("digest delivered on consecutive cycles");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("digest dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("digest changed while stalled");

    // Fresh out of reset, nothing can be ready to deliver.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid}))
        else $error("handshake signal unknown");

endmodule

bind md5_stream_hasher md5sh_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ test/md5_stream_hasher_test.sv @@
// Self-checking testbench for the streaming MD5 hasher with a built-in digest predictor.
`timescale 1ns / 1ps
module md5_stream_hasher_test;
    import md5sh_pkg::*;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } byte_op_t;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } digest_t;

    localparam int CycleLimit = 2000000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;

    byte_op_t pending_ops[$];
    digest_t  expected_digests[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       send_gap = 0;
    int       recv_gap = 0;
    int       hold_off = 0;
    int       digests_seen = 0;

    // Predictor state.
    logic [31:0] hash_words[4];
    logic [7:0]  block_buf[64];
    logic [60:0] byte_total;

    localparam logic [31:0] K_TABLE[64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int SHIFTS[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                  6, 10, 15, 21};

    function automatic logic [31:0] rotl(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    task automatic reset_hash();
        hash_words[0] = INIT_A;
        hash_words[1] = INIT_B;
        hash_words[2] = INIT_C;
        hash_words[3] = INIT_D;
        byte_total = '0;
    endtask

    task automatic compress_block_buf();
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, f, t;
        int g, grp;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i+3], block_buf[4*i+2], block_buf[4*i+1], block_buf[4*i]};
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
        for (int i = 0; i < 64; i++) begin
            grp = i / 16;
            case (grp)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            t = d; d = c; c = b;
            b = b + rotl(a + f + K_TABLE[i] + w[g], SHIFTS[grp * 4 + i % 4]);
            a = t;
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
    endtask

    task automatic absorb_byte(logic [7:0] v);
        int pos;
        pos = byte_total[5:0];
        block_buf[pos] = v;
        byte_total = byte_total + 1;
        if (pos == 63)
            compress_block_buf();
    endtask

    task automatic finish_digest();
        int pos;
        logic [63:0] bit_len;
        digest_t dg;
        pos = byte_total[5:0];
        bit_len = {byte_total, 3'b000};
        block_buf[pos] = PAD_BYTE;
        for (int i = pos + 1; i < 64; i++)
            block_buf[i] = 8'h00;
        if (pos >= 56) begin
            compress_block_buf();
            for (int i = 0; i < 64; i++)
                block_buf[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++)
            block_buf[56 + i] = bit_len[8*i +: 8];
        compress_block_buf();
        dg.digest_high = {byte_swap(hash_words[0]), byte_swap(hash_words[1])};
        dg.digest_low  = {byte_swap(hash_words[2]), byte_swap(hash_words[3])};
        expected_digests.push_back(dg);
        reset_hash();
    endtask

    task automatic predict_op(byte_op_t op);
        case (op.func)
            FUNC_APPEND: absorb_byte(op.data_byte);
            FUNC_APPEND_FINISH:
            begin
                absorb_byte(op.data_byte);
                finish_digest();
            end
            FUNC_FINISH: finish_digest();
            default: ;
        endcase
    endtask

    md5_stream_hasher DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 80);
    endfunction

    // Driver: predicts each transaction as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_op(byte_op_t'{s_axis_tuser, s_axis_tdata});
                void'(pending_ops.pop_front());
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (send_gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (pending_ops.size() > 0)
                begin
                    byte_op_t nx;
                    nx = pending_ops[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nx.func;
                    s_axis_tdata  <= nx.data_byte;
                    send_gap      <= pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver back-pressure; one long hold-off after the fourth digest.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
            hold_off      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                digest_t got;
                got = {m_axis_tdata[63:0], m_axis_tdata[127:64]};
                digests_seen <= digests_seen + 1;
                if (expected_digests.size() == 0)
                begin
                    $error("unexpected digest %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    digest_t exp_dg;
                    exp_dg = expected_digests.pop_front();
                    if (got.digest_high !== exp_dg.digest_high)
                    begin
                        $error("digest_high expected %h actual %h",
                               exp_dg.digest_high, got.digest_high);
                        error_count++;
                    end
                    if (got.digest_low !== exp_dg.digest_low)
                    begin
                        $error("digest_low expected %h actual %h",
                               exp_dg.digest_low, got.digest_low);
                        error_count++;
                    end
                end
                if (digests_seen == 3)
                    hold_off <= 3000;
            end
            if (hold_off > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off      <= hold_off - 1;
            end
            else if (recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap      <= recv_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                recv_gap      <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("md5_stream_hasher_test: errors");
            $finish;
        end
    end

    task automatic queue_message(int len, bit use_last_byte);
        for (int i = 0; i < len - (use_last_byte ? 1 : 0); i++)
            pending_ops.push_back(byte_op_t'{FUNC_APPEND, 8'($urandom)});
        if (use_last_byte)
            pending_ops.push_back(byte_op_t'{FUNC_APPEND_FINISH, 8'($urandom)});
        else
            pending_ops.push_back(byte_op_t'{FUNC_FINISH, 8'($urandom)});
    endtask

    initial
    begin
        int queued;
        int len;
        int r;
        reset_hash();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty message, an ignored selector, byte extremes, short tail.
        pending_ops.push_back(byte_op_t'{FUNC_FINISH, 8'hFF});
        pending_ops.push_back(byte_op_t'{FUNC_IGNORED, 8'hA5});
        pending_ops.push_back(byte_op_t'{FUNC_APPEND_FINISH, 8'h00});
        pending_ops.push_back(byte_op_t'{FUNC_APPEND, 8'hFF});
        pending_ops.push_back(byte_op_t'{FUNC_IGNORED, 8'h5A});
        pending_ops.push_back(byte_op_t'{FUNC_APPEND_FINISH, 8'h80});
        pending_ops.push_back(byte_op_t'{FUNC_APPEND, 8'h61});
        pending_ops.push_back(byte_op_t'{FUNC_APPEND, 8'h62});
        pending_ops.push_back(byte_op_t'{FUNC_APPEND, 8'h63});
        pending_ops.push_back(byte_op_t'{FUNC_FINISH, 8'h00});
        // Full block, long tail, and padding starting at position 55.
        queue_message(64, 0);
        queue_message(56, 1);
        queue_message(55, 0);
        queue_message(63, 1);
        queue_message(128, 1);
        queued = pending_ops.size();
        while (queued < 1600)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                len = $urandom_range(0, 12);
            else if (r < 85)
                len = $urandom_range(50, 70);
            else
                len = $urandom_range(100, 200);
            if (len == 0)
                queue_message(0, 0);
            else
                queue_message(len, $urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0)
                pending_ops.push_back(byte_op_t'{FUNC_IGNORED, 8'($urandom)});
            queued += len + 1;
        end

        wait (pending_ops.size() == 0);
        wait (expected_digests.size() == 0);
        repeat (300) @(posedge clk);
        if (error_count == 0 && expected_digests.size() == 0)
            $display("md5_stream_hasher_test: clean");
        else
            $display("md5_stream_hasher_test: errors");
        $finish;
    end

endmodule
